// ===== src/mpva_pkg.sv =====
// shared types, constants and functions of the polyphonic voice allocator
package mpva_pkg;

	localparam int VOICE_COUNT_DEFAULT = 4;
	localparam int VOICE_MAX           = 8;
	localparam int CMD_DEPTH_DEFAULT   = 2;
	localparam int NOTE_TABLE_DEPTH    = 128;
	localparam int PARK_VOICES         = 4;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_STATUS_A = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_STATUS_B = 1'd1;
	localparam logic [7:0] STATUS_A_RESET = 8'h99;
	localparam logic [7:0] STATUS_B_RESET = 8'h92;

	localparam logic [7:0] POT_RESET = 8'd128;
	localparam logic [7:0] POT_ZERO  = 8'd0;
	localparam logic [7:0] POT_FULL  = 8'd255;

	localparam logic [1:0] MODE_MIDI = 2'd0;
	localparam logic [1:0] MODE_POT  = 2'd1;

	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_NOTE_ON  = 2'd1;
	localparam logic [1:0] OP_NOTE_OFF = 2'd2;
	localparam logic [1:0] OP_POT      = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data;
		logic [3:0] osc_busy;
	} in_item_t;

	typedef struct packed {
		logic        is_load;
		logic [1:0]  voice;
		logic [15:0] period;
		logic [15:0] duty;
		logic        write_period;
		logic        write_duty;
		logic        gate_out;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] arg;
		logic [3:0] busy;
	} cmd_t;

	localparam logic [15:0] PERIOD_TABLE [NOTE_TABLE_DEPTH] = '{
		16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
		16'd0, 16'd0, 16'd0, 16'd64808,
		16'd61161, 16'd57736, 16'd54495, 16'd51413, 16'd48543, 16'd45808,
		16'd43252, 16'd40815, 16'd38520, 16'd36363, 16'd34316, 16'd32393,
		16'd30580, 16'd28859, 16'd27240, 16'd25713, 16'd24271, 16'd22909,
		16'd21621, 16'd20407, 16'd19263, 16'd18181, 16'd17160, 16'd16196,
		16'd15287, 16'd14429, 16'd13619, 16'd12856, 16'd12133, 16'd11452,
		16'd10810, 16'd10203, 16'd9630, 16'd9090, 16'd8580, 16'd8098,
		16'd7644, 16'd7215, 16'd6810, 16'd6427, 16'd6067, 16'd5726,
		16'd5404, 16'd5101, 16'd4815, 16'd4544, 16'd4289, 16'd4049,
		16'd3821, 16'd3607, 16'd3404, 16'd3213, 16'd3033, 16'd2862,
		16'd2702, 16'd2550, 16'd2407, 16'd2272, 16'd2144, 16'd2024,
		16'd1910, 16'd1803, 16'd1702, 16'd1606, 16'd1516, 16'd1431,
		16'd1350, 16'd1275, 16'd1203, 16'd1135, 16'd1072, 16'd1011,
		16'd955, 16'd901, 16'd850, 16'd803, 16'd757, 16'd715,
		16'd675, 16'd637, 16'd601, 16'd567, 16'd535, 16'd505,
		16'd477, 16'd450, 16'd425, 16'd401, 16'd378, 16'd357,
		16'd337, 16'd318, 16'd300, 16'd283, 16'd267, 16'd252,
		16'd238, 16'd224, 16'd212, 16'd200, 16'd189, 16'd178,
		16'd168, 16'd158, 16'd150, 16'd141, 16'd133, 16'd126,
		16'd118, 16'd111, 16'd105, 16'd99, 16'd94, 16'd88,
		16'd83, 16'd79
	};

	// pulse width as a binary-weighted fraction of the period
	function automatic logic [15:0] width_of(input logic [15:0] span, input logic [7:0] pot);
		logic [15:0] p2;
		logic [15:0] p1;
		logic [15:0] p0;
		logic [16:0] sum;
		p2 = span >> 7;
		if (p2 == 16'd0) begin
			p2 = 16'd1;
		end
		p1 = p2 >> 1;
		if (p1 == 16'd0) begin
			p1 = 16'd1;
		end
		p0 = p1 >> 1;
		if (p0 == 16'd0) begin
			p0 = 16'd1;
		end
		sum = 17'd0;
		if (pot[7]) sum = sum + 17'(span >> 2);
		if (pot[6]) sum = sum + 17'(span >> 3);
		if (pot[5]) sum = sum + 17'(span >> 4);
		if (pot[4]) sum = sum + 17'(span >> 5);
		if (pot[3]) sum = sum + 17'(span >> 6);
		if (pot[2]) sum = sum + 17'(p2);
		if (pot[1]) sum = sum + 17'(p1);
		if (pot[0]) sum = sum + 17'(p0);
		if (pot == POT_ZERO) begin
			width_of = 16'd0;
		end else if (pot == POT_FULL) begin
			width_of = span >> 1;
		end else begin
			width_of = sum[15:0];
		end
	endfunction

endpackage

// ===== src/midi_poly_voice_allocator_top.sv =====
// top level of the MIDI polyphonic voice allocator
// Usage:
//  - requests enter through push/full and request; each request is a MIDI byte,
//    a potentiometer sample or an idle tick, plus the per-oscillator busy bits
//  - results leave through empty/pop and result: zero or more oscillator loads,
//    always closed by one status result with last set and the gate level
//  - cfg_we/cfg_index/cfg_data write the two note-on status bytes; write them
//    only while no request is in flight
//  - the parser accepts one request per cycle into a short command queue
//    while it is not full; the voice engine handles one command at a time:
//    it applies it, recomputes duties (one for a new note, one per voice on
//    a potentiometer change), then emits the loads and the status result,
//    one result per cycle while the output is not stalled; a potentiometer
//    change that reloads every voice is the longest request, set by the
//    engine's shared read port and width unit
//  - the first result is registered after the queue, idle and width states
//  - reset clears all voices, pending loads and the gate, sets the
//    potentiometer value to mid scale and the status bytes to defaults
//  - a stalled pop holds the result register; the engine then stalls, the
//    queue fills and full rises
module midi_poly_voice_allocator_top #(
	parameter int VOICE_COUNT     = mpva_pkg::VOICE_COUNT_DEFAULT,
	parameter int CMD_QUEUE_DEPTH = mpva_pkg::CMD_DEPTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  mpva_pkg::in_item_t               request,
	output logic                             empty,
	input  logic                             pop,
	output mpva_pkg::out_item_t              result,
	input  logic                             cfg_we,
	input  logic [mpva_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mpva_pkg::CFG_DATA_W-1:0]  cfg_data
);

	mpva_pkg::cmd_t front_cmd;
	mpva_pkg::cmd_t queue_cmd;
	logic           accept;
	logic           queue_empty;
	logic           queue_pop;
	logic           out_valid;

	assign accept = push && !full;
	assign empty  = !out_valid;

	mpva_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.request   (request),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (front_cmd)
	);

	mpva_cmd_fifo #(
		.DEPTH (CMD_QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept),
		.wdata  (front_cmd),
		.full   (full),
		.rd     (queue_pop),
		.rdata  (queue_cmd),
		.empty  (queue_empty)
	);

	mpva_back #(
		.VOICE_COUNT (VOICE_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (queue_empty),
		.cmd       (queue_cmd),
		.cmd_pop   (queue_pop),
		.out_valid (out_valid),
		.out_item  (result),
		.out_pop   (pop)
	);

endmodule

// ===== src/mpva_front.sv =====
// byte parser: turns input requests into voice commands
module mpva_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  mpva_pkg::in_item_t                   request,
	input  logic                                 cfg_we,
	input  logic [mpva_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [mpva_pkg::CFG_DATA_W-1:0]      cfg_data,
	output mpva_pkg::cmd_t                       cmd
);

	localparam logic [1:0] PH_STATUS   = 2'd0;
	localparam logic [1:0] PH_NOTE     = 2'd1;
	localparam logic [1:0] PH_VELOCITY = 2'd2;

	logic [1:0] phase_q;
	logic [6:0] held_q;
	logic [7:0] status_a_q;
	logic [7:0] status_b_q;
	logic       status_hit;

	assign status_hit = (request.data == status_a_q) || (request.data == status_b_q);

	always_comb begin
		cmd.busy = request.osc_busy;
		cmd.arg  = request.data;
		cmd.op   = mpva_pkg::OP_TICK;
		if (request.mode == mpva_pkg::MODE_MIDI) begin
			if (phase_q == PH_VELOCITY) begin
				cmd.arg = {1'b0, held_q};
				cmd.op  = (request.data != 8'd0) ? mpva_pkg::OP_NOTE_ON : mpva_pkg::OP_NOTE_OFF;
			end
		end else if (request.mode == mpva_pkg::MODE_POT) begin
			cmd.op = mpva_pkg::OP_POT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_STATUS;
			held_q     <= 7'd0;
			status_a_q <= mpva_pkg::STATUS_A_RESET;
			status_b_q <= mpva_pkg::STATUS_B_RESET;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mpva_pkg::CFG_STATUS_A: status_a_q <= cfg_data;
					mpva_pkg::CFG_STATUS_B: status_b_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept && request.mode == mpva_pkg::MODE_MIDI) begin
				case (phase_q)
					PH_NOTE: begin
						held_q  <= request.data[6:0];
						phase_q <= PH_VELOCITY;
					end
					PH_VELOCITY: phase_q <= PH_STATUS;
					default: phase_q <= status_hit ? PH_NOTE : PH_STATUS;
				endcase
			end
		end
	end

endmodule

// ===== src/mpva_cmd_fifo.sv =====
// short command queue between the parser and the voice engine
module mpva_cmd_fifo #(
	parameter int DEPTH = mpva_pkg::CMD_DEPTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  mpva_pkg::cmd_t wdata,
	output logic           full,
	input  logic           rd,
	output mpva_pkg::cmd_t rdata,
	output logic           empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mpva_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0]  wptr_q;
	logic [AW-1:0]  rptr_q;
	logic [CW-1:0]  count_q;
	logic           do_wr;
	logic           do_rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/mpva_back.sv =====
// voice engine: allocation, duty recompute, oscillator loads and gate
module mpva_back #(
	parameter int VOICE_COUNT = mpva_pkg::VOICE_COUNT_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_empty,
	input  mpva_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	output logic                out_valid,
	output mpva_pkg::out_item_t out_item,
	input  logic                out_pop
);

	localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int PARK_N = (VOICE_COUNT < mpva_pkg::PARK_VOICES) ?
		VOICE_COUNT : mpva_pkg::PARK_VOICES;
	localparam logic [VIDX_W-1:0] PARK_LAST = VIDX_W'(PARK_N - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WIDTH = 3'd1;
	localparam logic [2:0] ST_PARK  = 3'd2;
	localparam logic [2:0] ST_LOAD  = 3'd3;

	logic [2:0]             state_q;
	logic [6:0]             note_q     [VOICE_COUNT];
	logic [VOICE_COUNT-1:0] vgate_q;
	logic [15:0]            pend_per_q [VOICE_COUNT];
	logic [15:0]            pend_dut_q [VOICE_COUNT];
	logic [15:0]            load_per_q [VOICE_COUNT];
	logic [VOICE_COUNT-1:0] busy_q;
	logic [VOICE_COUNT-1:0] wmask_q;
	logic                   wsrc_q;
	logic                   park_q;
	logic [VIDX_W-1:0]      park_idx_q;
	logic [7:0]             pot_q;
	logic                   gate_lvl_q;
	logic                   parked_q;
	logic                   out_valid_q;
	mpva_pkg::out_item_t    out_q;

	logic [6:0]             note;
	logic                   held;
	logic                   free_any;
	logic [VIDX_W-1:0]      free_idx;
	logic [VIDX_W-1:0]      widx;
	logic                   ready_any;
	logic [VIDX_W-1:0]      ready_idx;
	logic [VIDX_W-1:0]      rd_idx;
	logic [15:0]            per_rd;
	logic [15:0]            dut_rd;
	logic [15:0]            wval;
	logic                   any_gate;
	logic                   waiting;
	logic                   gate_next;
	logic                   out_ready;
	logic                   emit;
	logic [7:0]             busy_ext;
	mpva_pkg::out_item_t    emit_item;

	assign note      = cmd.arg[6:0];
	assign busy_ext  = {4'd0, cmd.busy};
	assign cmd_pop   = (state_q == ST_IDLE) && !cmd_empty;
	assign out_ready = !out_valid_q || out_pop;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		held      = 1'b0;
		free_any  = 1'b0;
		free_idx  = '0;
		widx      = '0;
		ready_any = 1'b0;
		ready_idx = '0;
		any_gate  = 1'b0;
		waiting   = 1'b0;
		for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
			if (note_q[i] == note) held = 1'b1;
			if (!vgate_q[i]) begin
				free_any = 1'b1;
				free_idx = VIDX_W'(i);
			end
			if (wmask_q[i]) widx = VIDX_W'(i);
			if (!busy_q[i] && (pend_per_q[i] != 16'd0 || pend_dut_q[i] != 16'd0)) begin
				ready_any = 1'b1;
				ready_idx = VIDX_W'(i);
			end
			if (vgate_q[i]) any_gate = 1'b1;
			if (pend_per_q[i] != 16'd0) waiting = 1'b1;
		end
	end

	// one shared read port into the voice arrays
	assign rd_idx    = (state_q == ST_WIDTH) ? widx : ready_idx;
	assign per_rd    = pend_per_q[rd_idx];
	assign dut_rd    = pend_dut_q[rd_idx];
	assign wval      = mpva_pkg::width_of(wsrc_q ? load_per_q[rd_idx] : per_rd, pot_q);
	assign gate_next = gate_lvl_q ? any_gate : (any_gate && !waiting);
	assign emit      = out_ready && ((state_q == ST_PARK) || (state_q == ST_LOAD));

	always_comb begin
		emit_item              = '0;
		emit_item.gate_out     = gate_lvl_q;
		if (state_q == ST_PARK) begin
			emit_item.is_load      = 1'b1;
			emit_item.voice        = 2'(park_idx_q);
			emit_item.period       = 16'd1;
			emit_item.duty         = 16'd1;
			emit_item.write_period = 1'b1;
			emit_item.write_duty   = 1'b1;
		end else if (ready_any) begin
			emit_item.is_load      = 1'b1;
			emit_item.voice        = 2'(ready_idx);
			emit_item.period       = per_rd;
			emit_item.duty         = dut_rd;
			emit_item.write_period = (per_rd != 16'd0);
			emit_item.write_duty   = (dut_rd != 16'd0);
		end else begin
			emit_item.gate_out     = gate_next;
			emit_item.last         = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vgate_q     <= '0;
			busy_q      <= '0;
			wmask_q     <= '0;
			wsrc_q      <= 1'b0;
			park_q      <= 1'b0;
			park_idx_q  <= '0;
			pot_q       <= mpva_pkg::POT_RESET;
			gate_lvl_q  <= 1'b0;
			parked_q    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < VOICE_COUNT; i++) begin
				note_q[i]     <= 7'd0;
				pend_per_q[i] <= 16'd0;
				pend_dut_q[i] <= 16'd0;
				load_per_q[i] <= 16'd0;
			end
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						busy_q  <= busy_ext[VOICE_COUNT-1:0];
						park_q  <= 1'b0;
						wsrc_q  <= 1'b0;
						state_q <= ST_WIDTH;
						case (cmd.op)
							mpva_pkg::OP_NOTE_ON: begin
								if (!parked_q) begin
									park_q   <= 1'b1;
									parked_q <= 1'b1;
								end
								if (!held && free_any) begin
									note_q[free_idx]     <= note;
									vgate_q[free_idx]    <= 1'b1;
									pend_per_q[free_idx] <= mpva_pkg::PERIOD_TABLE[note];
									wmask_q[free_idx]    <= 1'b1;
								end
							end
							mpva_pkg::OP_NOTE_OFF: begin
								for (int i = 0; i < VOICE_COUNT; i++) begin
									if (note_q[i] == note) begin
										note_q[i]  <= 7'd0;
										vgate_q[i] <= 1'b0;
									end
								end
							end
							mpva_pkg::OP_POT: begin
								if (cmd.arg != pot_q) begin
									pot_q   <= cmd.arg;
									wmask_q <= '1;
									wsrc_q  <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				ST_WIDTH: begin
					// one duty recompute per cycle, lowest voice first
					if (wmask_q != '0) begin
						pend_dut_q[widx] <= wval;
						wmask_q[widx]    <= 1'b0;
					end else if (park_q && PARK_N > 1) begin
						park_idx_q <= VIDX_W'(1);
						state_q    <= ST_PARK;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_PARK: begin
					if (out_ready) begin
						busy_q[park_idx_q] <= 1'b1;
						if (park_idx_q == PARK_LAST) begin
							state_q <= ST_LOAD;
						end else begin
							park_idx_q <= park_idx_q + 1'b1;
						end
					end
				end
				ST_LOAD: begin
					if (out_ready) begin
						if (ready_any) begin
							if (per_rd != 16'd0) begin
								load_per_q[ready_idx] <= per_rd;
							end
							pend_per_q[ready_idx] <= 16'd0;
							pend_dut_q[ready_idx] <= 16'd0;
						end else begin
							gate_lvl_q <= gate_next;
							if (gate_lvl_q && !any_gate) begin
								parked_q <= 1'b0;
							end
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_status_ends_request: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && out_ready && !ready_any) |=> (state_q == ST_IDLE))
		else $error("engine did not return to idle after the status result");

	a_park_only_when_parked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PARK) |-> (parked_q && park_q))
		else $error("park loads emitted without park flag");

	a_no_duty_work_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (wmask_q == '0))
		else $error("duty recompute left pending in idle");

	a_gate_fall_unparks: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(gate_lvl_q) |-> !parked_q)
		else $error("gate fell but voices stay parked");

endmodule

// ===== verif/osc_load_tracker_pkg.sv =====
`timescale 1ns / 1ps
// scoreboard class that predicts and checks the voice allocator's oscillator loads
package osc_load_tracker_pkg;
	import mpva_pkg::*;

	localparam int VOICES = VOICE_COUNT_DEFAULT;

	typedef enum logic [1:0] {
		AWAIT_STATUS,
		AWAIT_NOTE,
		AWAIT_VELOCITY
	} parse_phase_e;

	// tone period per note number, zero below the lowest playable note
	localparam logic [15:0] TONE_PERIOD [128] = '{
		16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd64808,
		16'd61161, 16'd57736, 16'd54495, 16'd51413, 16'd48543, 16'd45808, 16'd43252, 16'd40815,
		16'd38520, 16'd36363, 16'd34316, 16'd32393, 16'd30580, 16'd28859, 16'd27240, 16'd25713,
		16'd24271, 16'd22909, 16'd21621, 16'd20407, 16'd19263, 16'd18181, 16'd17160, 16'd16196,
		16'd15287, 16'd14429, 16'd13619, 16'd12856, 16'd12133, 16'd11452, 16'd10810, 16'd10203,
		16'd9630, 16'd9090, 16'd8580, 16'd8098, 16'd7644, 16'd7215, 16'd6810, 16'd6427,
		16'd6067, 16'd5726, 16'd5404, 16'd5101, 16'd4815, 16'd4544, 16'd4289, 16'd4049,
		16'd3821, 16'd3607, 16'd3404, 16'd3213, 16'd3033, 16'd2862, 16'd2702, 16'd2550,
		16'd2407, 16'd2272, 16'd2144, 16'd2024, 16'd1910, 16'd1803, 16'd1702, 16'd1606,
		16'd1516, 16'd1431, 16'd1350, 16'd1275, 16'd1203, 16'd1135, 16'd1072, 16'd1011,
		16'd955, 16'd901, 16'd850, 16'd803, 16'd757, 16'd715, 16'd675, 16'd637,
		16'd601, 16'd567, 16'd535, 16'd505, 16'd477, 16'd450, 16'd425, 16'd401,
		16'd378, 16'd357, 16'd337, 16'd318, 16'd300, 16'd283, 16'd267, 16'd252,
		16'd238, 16'd224, 16'd212, 16'd200, 16'd189, 16'd178, 16'd168, 16'd158,
		16'd150, 16'd141, 16'd133, 16'd126, 16'd118, 16'd111, 16'd105, 16'd99,
		16'd94, 16'd88, 16'd83, 16'd79
	};

	class osc_load_tracker;
		logic [7:0]   status_a;
		logic [7:0]   status_b;
		parse_phase_e phase;
		logic [6:0]   held_note;
		logic [6:0]   voice_note [VOICES];
		logic         voice_on [VOICES];
		logic [15:0]  next_period [VOICES];
		logic [15:0]  next_width [VOICES];
		logic [15:0]  live_period [VOICES];
		logic [7:0]   pot;
		logic         gate;
		logic         parked;
		out_item_t    due_loads [$];
		int           miss_count;

		function new();
			status_a = STATUS_A_RESET;
			status_b = STATUS_B_RESET;
			phase = AWAIT_STATUS;
			held_note = 7'd0;
			for (int i = 0; i < VOICES; i++) begin
				voice_note[i] = 7'd0;
				voice_on[i] = 1'b0;
				next_period[i] = 16'd0;
				next_width[i] = 16'd0;
				live_period[i] = 16'd0;
			end
			pot = POT_RESET;
			gate = 1'b0;
			parked = 1'b0;
			miss_count = 0;
		endfunction

		function void set_status(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
			if (idx == CFG_STATUS_A) begin
				status_a = val;
			end else if (idx == CFG_STATUS_B) begin
				status_b = val;
			end
		endfunction

		// each pot bit adds a halving share of the span; the three low shares never drop below 1
		function logic [15:0] pulse_width(input logic [15:0] span);
			logic [31:0] sum;
			logic [15:0] part;
			sum = 32'd0;
			part = span >> 2;
			if (pot == POT_ZERO) return 16'd0;
			if (pot == POT_FULL) return span >> 1;
			for (int b = 7; b >= 0; b--) begin
				if (b <= 2) begin
					part = part >> 1;
					if (part == 16'd0) part = 16'd1;
				end else if (b < 7) begin
					part = part >> 1;
				end
				if (pot[b]) sum = sum + 32'(part);
			end
			return sum[15:0];
		endfunction

		function void push_load(input logic ld, input logic [1:0] v, input logic [15:0] p,
				input logic [15:0] d, input logic wp, input logic wd, input logic fin);
			out_item_t r;
			r.is_load = ld;
			r.voice = v;
			r.period = p;
			r.duty = d;
			r.write_period = wp;
			r.write_duty = wd;
			r.gate_out = gate;
			r.last = fin;
			due_loads.push_back(r);
		endfunction

		function void take_request(input in_item_t req);
			logic [3:0] busy;
			logic       park_now;
			logic       held;
			logic       any;
			logic       waiting;
			busy = req.osc_busy;
			park_now = 1'b0;
			if (req.mode == MODE_MIDI) begin
				if (phase == AWAIT_NOTE) begin
					held_note = req.data[6:0];
					phase = AWAIT_VELOCITY;
				end else if (phase == AWAIT_VELOCITY) begin
					phase = AWAIT_STATUS;
					if (req.data != 8'd0) begin
						if (!parked) begin
							park_now = 1'b1;
							parked = 1'b1;
						end
						held = 1'b0;
						for (int i = 0; i < VOICES; i++)
							if (voice_note[i] == held_note) held = 1'b1;
						if (!held) begin
							for (int i = 0; i < VOICES; i++) begin
								if (!voice_on[i]) begin
									voice_note[i] = held_note;
									voice_on[i] = 1'b1;
									next_period[i] = TONE_PERIOD[held_note];
									next_width[i] = pulse_width(next_period[i]);
									break;
								end
							end
						end
					end else begin
						// a free voice holds note zero, so note-off zero only touches free voices
						for (int i = 0; i < VOICES; i++) begin
							if (voice_note[i] == held_note) begin
								voice_note[i] = 7'd0;
								voice_on[i] = 1'b0;
							end
						end
					end
				end else begin
					phase = (req.data == status_a || req.data == status_b) ?
						AWAIT_NOTE : AWAIT_STATUS;
				end
			end else if (req.mode == MODE_POT) begin
				if (req.data != pot) begin
					pot = req.data;
					for (int i = 0; i < VOICES; i++)
						next_width[i] = pulse_width(live_period[i]);
				end
			end

			// parked voices take a dummy load and count as busy for this request
			if (park_now) begin
				for (int i = 1; i < VOICES; i++) begin
					push_load(1'b1, 2'(i), 16'd1, 16'd1, 1'b1, 1'b1, 1'b0);
					busy[i] = 1'b1;
				end
			end

			for (int i = 0; i < VOICES; i++) begin
				if (busy[i]) continue;
				if (next_period[i] == 16'd0 && next_width[i] == 16'd0) continue;
				push_load(1'b1, 2'(i), next_period[i], next_width[i],
					next_period[i] != 16'd0, next_width[i] != 16'd0, 1'b0);
				if (next_period[i] != 16'd0) live_period[i] = next_period[i];
				next_period[i] = 16'd0;
				next_width[i] = 16'd0;
			end

			any = 1'b0;
			waiting = 1'b0;
			for (int i = 0; i < VOICES; i++) begin
				if (voice_on[i]) any = 1'b1;
				if (next_period[i] != 16'd0) waiting = 1'b1;
			end
			if (!gate) begin
				if (any && !waiting) gate = 1'b1;
			end else if (!any) begin
				gate = 1'b0;
				parked = 1'b0;
			end

			push_load(1'b0, 2'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1);
		endfunction

		task report_miss(input string msg);
			if (miss_count < 50) $display("load check: %s", msg);
			miss_count++;
		endtask

		task match_load(input out_item_t got);
			out_item_t want;
			string     bad;
			if (due_loads.size() == 0) begin
				report_miss($sformatf("result %h with nothing waiting", got));
				return;
			end
			want = due_loads.pop_front();
			bad = "";
			if (got.is_load !== want.is_load) bad = {bad, " is_load"};
			if (got.voice !== want.voice) bad = {bad, " voice"};
			if (got.period !== want.period) bad = {bad, " period"};
			if (got.duty !== want.duty) bad = {bad, " duty"};
			if (got.write_period !== want.write_period) bad = {bad, " write_period"};
			if (got.write_duty !== want.write_duty) bad = {bad, " write_duty"};
			if (got.gate_out !== want.gate_out) bad = {bad, " gate_out"};
			if (got.last !== want.last) bad = {bad, " last"};
			if (bad != "") report_miss($sformatf("bad%s: got %h want %h", bad, got, want));
		endtask
	endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// testbench top: drives MIDI bytes, pot samples and ticks into the voice allocator
module tb_top;
	import mpva_pkg::*;
	import osc_load_tracker_pkg::*;

	localparam logic [1:0] MODE_TICK  = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int IDLE_LIMIT   = 5000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 24;
	localparam int PHASE_ITEMS  = 78;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   push = 1'b0;
	logic                   full;
	in_item_t               request = '0;
	logic                   empty;
	logic                   pop = 1'b0;
	out_item_t              result;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	logic hold_off = 1'b0;
	int   idle_cycles = 0;
	int   sent = 0;
	int   burst_left = 0;
	logic [6:0] note_pool [8] = '{7'd0, 7'd5, 7'd11, 7'd47, 7'd60, 7'd61, 7'd62, 7'd127};

	osc_load_tracker tracker = new();

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	midi_poly_voice_allocator_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) tracker.take_request(request);
			if (pop && !empty) tracker.match_load(result);
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("midi_poly_voice_allocator_top: mismatch");
		$finish;
	end

	// receiver: pops follow a random 16-bit stall pattern that is redrawn periodically; long hold-off on request
	initial begin : receiver
		logic [15:0] stall_pattern;
		int          step_no;
		int          hold_left;
		stall_pattern = '1;
		step_no = 0;
		hold_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (hold_off) begin
				hold_off = 1'b0;
				hold_left = HOLD_CYCLES;
				pop <= 1'b0;
			end else begin
				if (step_no % 64 == 0) begin
					case ($urandom_range(3))
						0: stall_pattern = '1;
						1: stall_pattern = 16'($urandom);
						2: stall_pattern = 16'($urandom & $urandom);
						default: stall_pattern = 16'($urandom | $urandom);
					endcase
				end
				pop <= stall_pattern[step_no % 16];
				step_no++;
			end
		end
	end

	function automatic in_item_t make_item(input logic [1:0] m, input logic [7:0] d,
			input logic [3:0] b);
		in_item_t it;
		it.mode = m;
		it.data = d;
		it.osc_busy = b;
		return it;
	endfunction

	function automatic logic [3:0] rand_busy();
		return ($urandom_range(3) != 0) ? 4'd0 : 4'($urandom);
	endfunction

	function automatic logic [7:0] rand_note();
		if ($urandom_range(3) == 0) return 8'($urandom);
		return {1'($urandom_range(1)), note_pool[$urandom_range(7)]};
	endfunction

	function automatic logic [7:0] rand_pot();
		case ($urandom_range(5))
			0: return POT_ZERO;
			1: return POT_FULL;
			2: return POT_RESET;
			default: return 8'($urandom);
		endcase
	endfunction

	// sender works in bursts; a gap of idle cycles may come before a new burst
	task automatic send(input in_item_t item);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		request <= item;
		do @(posedge clk); while (full);
		sent++;
	endtask

	task automatic play(input logic [7:0] st, input logic [7:0] note, input logic [7:0] vel);
		send(make_item(MODE_MIDI, st, rand_busy()));
		send(make_item(MODE_MIDI, note, rand_busy()));
		send(make_item(MODE_MIDI, vel, rand_busy()));
	endtask

	// let the last accepted request be predicted before waiting for the due results to drain
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (tracker.due_loads.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_status(input logic [7:0] a, input logic [7:0] b);
		cfg_we <= 1'b1;
		cfg_index <= CFG_STATUS_A;
		cfg_data <= a;
		@(posedge clk);
		cfg_index <= CFG_STATUS_B;
		cfg_data <= b;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_status(CFG_STATUS_A, a);
		tracker.set_status(CFG_STATUS_B, b);
	endtask

	task automatic random_step();
		int         pick;
		logic [7:0] st;
		logic [7:0] vel;
		pick = $urandom_range(99);
		st = $urandom_range(1) ? tracker.status_a : tracker.status_b;
		vel = ($urandom_range(9) < 4) ? 8'd0 : 8'($urandom_range(1, 255));
		if (pick < 60) begin
			play(st, rand_note(), vel);
		end else if (pick < 75) begin
			send(make_item(MODE_POT, rand_pot(), rand_busy()));
		end else if (pick < 85) begin
			send(make_item($urandom_range(1) ? MODE_TICK : MODE_SPARE, 8'($urandom), rand_busy()));
		end else if (pick < 92) begin
			send(make_item(MODE_MIDI, 8'($urandom), rand_busy()));
		end else begin
			// broken message: the next status byte lands in the velocity slot
			send(make_item(MODE_MIDI, st, rand_busy()));
			send(make_item(MODE_MIDI, rand_note(), rand_busy()));
		end
	endtask

	initial begin : stimulus
		logic [7:0] pick_a [5];
		logic [7:0] pick_b [5];
		int         target;
		logic       pressed;
		logic       paused;
		pick_a = '{8'h90, 8'h00, 8'hFF, 8'h00, STATUS_A_RESET};
		pick_b = '{8'h9F, 8'hFF, 8'h00, 8'h00, STATUS_B_RESET};
		pressed = 1'b0;
		paused = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(make_item(MODE_TICK, 8'h00, 4'h0));
		send(make_item(MODE_SPARE, 8'hFF, 4'hF));
		// first note parks voices 1-3; note zero never gets a voice
		play(STATUS_A_RESET, 8'h00, 8'h7F);
		// low note sounds with no period to load
		play(STATUS_B_RESET, 8'h05, 8'h01);
		// top note with the high bit set, held back by busy oscillators
		send(make_item(MODE_MIDI, STATUS_A_RESET, 4'h0));
		send(make_item(MODE_MIDI, 8'hFF, 4'h0));
		send(make_item(MODE_MIDI, 8'h40, 4'hF));
		send(make_item(MODE_TICK, 8'h00, 4'h0));
		send(make_item(MODE_POT, POT_FULL, 4'h0));
		send(make_item(MODE_POT, POT_ZERO, 4'h0));
		send(make_item(MODE_MIDI, 8'h45, 4'h0));
		// status bytes in the note and velocity slots count as data
		send(make_item(MODE_MIDI, STATUS_A_RESET, 4'h0));
		send(make_item(MODE_MIDI, STATUS_B_RESET, 4'h0));
		send(make_item(MODE_MIDI, STATUS_A_RESET, 4'h0));
		play(STATUS_B_RESET, 8'h05, 8'h00);
		play(STATUS_A_RESET, 8'h7F, 8'h00);

		for (int ph = 0; ph < 5; ph++) begin
			settle();
			if (ph == 3) begin
				pick_a[ph] = 8'($urandom);
				pick_b[ph] = 8'($urandom);
			end
			write_status(pick_a[ph], pick_b[ph]);
			target = sent + PHASE_ITEMS;
			while (sent < target) begin
				if (ph == 1 && !pressed && sent >= target - 40) begin
					pressed = 1'b1;
					hold_off = 1'b1;
					burst_left = 40;
					repeat (10) play(tracker.status_a, rand_note(), 8'($urandom_range(1, 255)));
				end else if (ph == 3 && !paused && sent >= target - 40) begin
					paused = 1'b1;
					settle();
				end else begin
					random_step();
				end
			end
		end

		settle();
		if (tracker.due_loads.size() != 0)
			tracker.report_miss($sformatf("%0d results never came", tracker.due_loads.size()));
		if (tracker.miss_count == 0) begin
			$display("midi_poly_voice_allocator_top: match");
		end else begin
			$display("midi_poly_voice_allocator_top: mismatch");
		end
		$finish;
	end

endmodule
